// ----- rtl/psu_pkg.sv -----
// Shared types and constants for the particle swarm update engine.
package psu_pkg;

   localparam int DATA_W = 32;
   localparam int WEIGHT_W = 16;
   localparam int COEF_W = 18;
   localparam int CSR_ADDR_W = 5;
   localparam logic [DATA_W-1:0] ALL_ONES = '1;

   localparam logic [3:0] DIMS_RESET = 4'd3;
   localparam logic [WEIGHT_W-1:0] INERTIA_START_RESET = 16'd16384;
   localparam logic [WEIGHT_W-1:0] INERTIA_FLOOR_RESET = 16'd6554;
   localparam logic [WEIGHT_W-1:0] INERTIA_STEP_RESET = 16'd164;
   localparam logic [WEIGHT_W-1:0] PERSONAL_W_RESET = 16'd32768;
   localparam logic [WEIGHT_W-1:0] GLOBAL_W_RESET = 16'd32768;

   typedef enum logic [2:0] {
      CMD_LOAD_BOUND = 3'd0,
      CMD_LOAD_PART  = 3'd1,
      CMD_REPORT     = 3'd2,
      CMD_MOVE       = 3'd3,
      CMD_ITER       = 3'd4
   } psu_cmd_type;

   typedef enum logic [1:0] {
      KIND_MOVE   = 2'd0,
      KIND_REPORT = 2'd1,
      KIND_ITER   = 2'd2
   } psu_kind_type;

   typedef enum logic [2:0] {
      REG_DIMS          = 3'd0,
      REG_INERTIA_START = 3'd1,
      REG_INERTIA_FLOOR = 3'd2,
      REG_INERTIA_STEP  = 3'd3,
      REG_PERSONAL_W    = 3'd4,
      REG_GLOBAL_W      = 3'd5
   } psu_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MV_RD,
      ST_MV_MUL,
      ST_MV_SUM,
      ST_MV_OUT,
      ST_RP_CMP,
      ST_RP_CRD,
      ST_RP_CWR,
      ST_EMIT
   } psu_state_type;

   typedef struct packed {
      psu_kind_type        kind;
      logic [5:0]          out_particle;
      logic [2:0]          out_dim;
      logic [DATA_W-1:0]   new_position;
      logic [DATA_W-1:0]   new_velocity;
      logic                personal_improved;
      logic                global_improved;
      logic [DATA_W-1:0]   best_cost;
      logic [5:0]          best_particle;
      logic [WEIGHT_W-1:0] inertia_now;
      logic                last;
   } psu_rsp_type;

endpackage

// ----- rtl/psu_ifs.sv -----
// Request and response channel interfaces of the particle swarm update engine.
interface psu_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [5:0]  particle;
   logic [2:0]  dim_index;
   logic [31:0] value_a;
   logic [31:0] value_b;
   logic [31:0] cost;
   logic [15:0] rand_personal;
   logic [15:0] rand_global;

   modport source (output valid, cmd, particle, dim_index, value_a, value_b, cost,
      rand_personal, rand_global, input ready);
   modport sink (input valid, cmd, particle, dim_index, value_a, value_b, cost,
      rand_personal, rand_global, output ready);
endinterface

interface psu_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [5:0]  out_particle;
   logic [2:0]  out_dim;
   logic [31:0] new_position;
   logic [31:0] new_velocity;
   logic        personal_improved;
   logic        global_improved;
   logic [31:0] best_cost;
   logic [5:0]  best_particle;
   logic [15:0] inertia_now;
   logic        last;

   modport source (output valid, kind, out_particle, out_dim, new_position,
      new_velocity, personal_improved, global_improved, best_cost, best_particle,
      inertia_now, last, input ready);
   modport sink (input valid, kind, out_particle, out_dim, new_position,
      new_velocity, personal_improved, global_improved, best_cost, best_particle,
      inertia_now, last, output ready);
endinterface

// ----- rtl/psu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module psu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/particle_swarm_update_engine_top.sv -----
// Top level of the particle swarm update engine: sequencer, datapath and state memories.
//
//  channel  | role   | handshake          | carries
//  req_ch   | sink   | valid/ready        | command, particle, dimension, values, cost, draws
//  rsp_ch   | source | valid/ready        | one result per dimension moved, or one per report/iter
//  csr_*    | slave  | APB, pready high   | six configuration registers at 4*i
//
// A move runs read, multiply, sum and write-back for each of the n dimensions in use, through
// the particle state memory (position, velocity, personal best).
// A report compares costs, then copies every dimension through the memories when a best changes.
// Loads are done in the idle state; an end of iteration emits its response from the emit state.
// Reset is synchronous; personal best costs read as all ones until written (valid bits).
// A stalled response holds the sequencer in its output state; input is taken only when idle.
module particle_swarm_update_engine_top
   import psu_pkg::*;
#(
   parameter int MAX_PARTICLES = 64,
   parameter int MAX_DIMS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   psu_req_if.sink               req_ch,
   psu_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]     csr_prdata,
   output logic                  csr_pready
);

   localparam int PW = $clog2(MAX_PARTICLES);
   localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int SLOTS = 2 ** DW;
   localparam int AW = PW + DW;
   localparam int PDEPTH = 2 ** PW;
   localparam int SDEPTH = PDEPTH * SLOTS;

   psu_state_type state_ff, state_in;

   logic [3:0]          dims_ff;
   logic [WEIGHT_W-1:0] inertia_start_ff, inertia_floor_ff, inertia_step_ff;
   logic [WEIGHT_W-1:0] personal_w_ff, global_w_ff, inertia_ff;

   logic signed [DATA_W-1:0] lo_ff [SLOTS];
   logic signed [DATA_W-1:0] hi_ff [SLOTS];
   logic signed [DATA_W-1:0] gb_ff [SLOTS];
   logic [MAX_PARTICLES-1:0] pcv_ff;
   logic [DATA_W-1:0]        gcost_ff;
   logic [5:0]               gidx_ff;

   logic [5:0]             part_ff;
   logic [DW-1:0]          d_ff;
   logic [DATA_W-1:0]      cost_ff;
   logic [COEF_W-1:0]      cp_ff, cg_ff;
   logic signed [DATA_W-1:0] pos_ff, nv_ff;
   logic signed [51:0]     t0_ff, t1_ff, t2_ff;
   logic                   pimp_ff, gimp_ff;
   psu_kind_type           kind_ff;

   psu_rsp_type rsp_ff, rsp_in;
   logic        rsp_vld_ff;
   logic        rsp_load, slot_free;

   logic req_fire, cfg_wr, p_ok, d_ok;
   logic [PW-1:0] p_req, p_cur;
   logic [DW-1:0] d_req, dims_last;
   logic last_dim;
   psu_cmd_type cmd_c;

   logic [AW-1:0] rd_addr, wr_addr;
   logic st_we, pc_we;
   logic [DATA_W-1:0] pos_wd, vel_wd, pb_wd, pc_wd;
   logic [DATA_W-1:0] pos_rd, vel_rd, pb_rd, pc_rd;
   logic [3*DATA_W-1:0] st_wd, st_rd;

   logic [DATA_W-1:0] pc_eff, newpc;
   logic              pimp_c, gimp_c;
   logic [16:0]       iw_diff;
   logic [WEIGHT_W-1:0] iw_next;
   logic [31:0]       cp_prod, cg_prod;
   logic signed [16:0] w_s;
   logic signed [18:0] cp_s, cg_s;
   logic signed [32:0] dpb_s, dgb_s;
   logic signed [51:0] prod0_c, prod1_c, prod2_c;
   logic signed [53:0] sum_c;
   logic signed [37:0] nvw_c;
   logic signed [DATA_W-1:0] nv_c, np_fin;
   logic signed [32:0] np_c, np_clip;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cmd_c = psu_cmd_type'(req_ch.cmd);
   assign p_ok = 32'(req_ch.particle) < MAX_PARTICLES;
   assign d_ok = 32'(req_ch.dim_index) < MAX_DIMS;
   assign p_req = PW'(req_ch.particle);
   assign d_req = DW'(req_ch.dim_index);
   assign p_cur = PW'(part_ff);
   assign slot_free = !rsp_vld_ff || rsp_ch.ready;

   always_comb begin
      if (dims_ff == 4'd0) begin
         dims_last = '0;
      end else if (32'(dims_ff) > MAX_DIMS) begin
         dims_last = DW'(MAX_DIMS - 1);
      end else begin
         dims_last = DW'(dims_ff - 4'd1);
      end
   end
   assign last_dim = (d_ff == dims_last);

   // state memories
   assign st_wd = {pos_wd, vel_wd, pb_wd};
   assign pos_rd = st_rd[3*DATA_W-1:2*DATA_W];
   assign vel_rd = st_rd[2*DATA_W-1:DATA_W];
   assign pb_rd = st_rd[DATA_W-1:0];

   psu_ram #(.WIDTH(3*DATA_W), .DEPTH(SDEPTH)) u_state_ram (
      .clock(clock), .wr_en(st_we), .wr_addr(wr_addr), .wr_data(st_wd),
      .rd_addr(rd_addr), .rd_data(st_rd));
   psu_ram #(.WIDTH(DATA_W), .DEPTH(PDEPTH)) u_pc_ram (
      .clock(clock), .wr_en(pc_we), .wr_addr(state_ff == ST_IDLE ? p_req : p_cur),
      .wr_data(pc_wd), .rd_addr(p_req), .rd_data(pc_rd));

   // report compare
   assign pc_eff = pcv_ff[p_cur] ? pc_rd : ALL_ONES;
   assign pimp_c = cost_ff < pc_eff;
   assign newpc = pimp_c ? cost_ff : pc_eff;
   assign gimp_c = newpc < gcost_ff;

   // inertia decay
   assign iw_diff = {1'b0, inertia_ff} - {1'b0, inertia_step_ff};
   assign iw_next = (iw_diff[16] || iw_diff[15:0] < inertia_floor_ff) ?
      inertia_floor_ff : iw_diff[15:0];

   // move datapath
   assign cp_prod = personal_w_ff * req_ch.rand_personal;
   assign cg_prod = global_w_ff * req_ch.rand_global;
   assign w_s = signed'({1'b0, inertia_ff});
   assign cp_s = signed'({1'b0, cp_ff});
   assign cg_s = signed'({1'b0, cg_ff});
   assign dpb_s = 33'(signed'(pb_rd)) - 33'(signed'(pos_rd));
   assign dgb_s = 33'(gb_ff[d_ff]) - 33'(signed'(pos_rd));
   assign prod0_c = 52'(w_s * signed'(vel_rd));
   assign prod1_c = 52'(cp_s * dpb_s);
   assign prod2_c = 52'(cg_s * dgb_s);
   assign sum_c = 54'(t0_ff) + 54'(t1_ff) + 54'(t2_ff);
   assign nvw_c = sum_c[53:16];

   always_comb begin
      if (!nvw_c[37] && (nvw_c[36:31] != 6'd0)) begin
         nv_c = 32'sh7FFFFFFF;
      end else if (nvw_c[37] && (nvw_c[36:31] != 6'h3F)) begin
         nv_c = 32'sh80000000;
      end else begin
         nv_c = nvw_c[31:0];
      end
   end

   assign np_c = 33'(pos_ff) + 33'(nv_ff);
   always_comb begin
      np_clip = np_c;
      if (np_clip > 33'(hi_ff[d_ff])) begin
         np_clip = 33'(hi_ff[d_ff]);
      end
      if (np_clip < 33'(lo_ff[d_ff])) begin
         np_clip = 33'(lo_ff[d_ff]);
      end
      np_fin = np_clip[31:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (cmd_c)
                  CMD_REPORT: if (p_ok) state_in = ST_RP_CMP;
                  CMD_MOVE:   if (p_ok) state_in = ST_MV_RD;
                  CMD_ITER:   state_in = ST_EMIT;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_MV_RD:  state_in = ST_MV_MUL;
         ST_MV_MUL: state_in = ST_MV_SUM;
         ST_MV_SUM: state_in = ST_MV_OUT;
         ST_MV_OUT: if (slot_free) state_in = last_dim ? ST_IDLE : ST_MV_RD;
         ST_RP_CMP: state_in = (pimp_c || gimp_c) ? ST_RP_CRD : ST_EMIT;
         ST_RP_CRD: state_in = ST_RP_CWR;
         ST_RP_CWR: state_in = last_dim ? ST_EMIT : ST_RP_CRD;
         ST_EMIT:   if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ch.ready = 1'b0;
      st_we = 1'b0;
      pc_we = 1'b0;
      rsp_load = 1'b0;
      rd_addr = {p_cur, d_ff};
      wr_addr = {p_cur, d_ff};
      pos_wd = np_fin;
      vel_wd = nv_ff;
      pb_wd = pb_rd;
      pc_wd = cost_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            wr_addr = {p_req, d_req};
            pos_wd = req_ch.value_a;
            vel_wd = req_ch.value_b;
            pb_wd = req_ch.value_a;
            pc_wd = ALL_ONES;
            if (req_fire && cmd_c == CMD_LOAD_PART && p_ok && d_ok) begin
               st_we = 1'b1;
               pc_we = 1'b1;
            end
         end
         ST_MV_OUT: begin
            if (slot_free) begin
               st_we = 1'b1;
               rsp_load = 1'b1;
            end
         end
         ST_RP_CMP: pc_we = pimp_c;
         ST_RP_CWR: begin
            pos_wd = pos_rd;
            vel_wd = vel_rd;
            pb_wd = pos_rd;
            st_we = pimp_ff;
         end
         ST_EMIT:   rsp_load = slot_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.best_cost = gcost_ff;
      rsp_in.best_particle = gidx_ff;
      rsp_in.inertia_now = inertia_ff;
      rsp_in.last = 1'b1;
      if (state_ff == ST_MV_OUT) begin
         rsp_in.kind = KIND_MOVE;
         rsp_in.out_particle = part_ff;
         rsp_in.out_dim = 3'(d_ff);
         rsp_in.new_position = np_fin;
         rsp_in.new_velocity = nv_ff;
         rsp_in.last = last_dim;
      end else begin
         rsp_in.kind = kind_ff;
         if (kind_ff == KIND_REPORT) begin
            rsp_in.out_particle = part_ff;
            rsp_in.personal_improved = pimp_ff;
            rsp_in.global_improved = gimp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_vld_ff <= rsp_load || (rsp_vld_ff && !rsp_ch.ready);
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= DIMS_RESET;
         inertia_start_ff <= INERTIA_START_RESET;
         inertia_floor_ff <= INERTIA_FLOOR_RESET;
         inertia_step_ff <= INERTIA_STEP_RESET;
         personal_w_ff <= PERSONAL_W_RESET;
         global_w_ff <= GLOBAL_W_RESET;
         inertia_ff <= INERTIA_START_RESET;
      end else if (cfg_wr) begin
         unique case (psu_reg_type'(csr_paddr[4:2]))
            REG_DIMS:          dims_ff <= csr_pwdata[3:0];
            REG_INERTIA_START: begin
               inertia_start_ff <= csr_pwdata[15:0];
               inertia_ff <= csr_pwdata[15:0];
            end
            REG_INERTIA_FLOOR: inertia_floor_ff <= csr_pwdata[15:0];
            REG_INERTIA_STEP:  inertia_step_ff <= csr_pwdata[15:0];
            REG_PERSONAL_W:    personal_w_ff <= csr_pwdata[15:0];
            REG_GLOBAL_W:      global_w_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end else if (req_fire && cmd_c == CMD_ITER) begin
         inertia_ff <= iw_next;
      end
   end

   always_comb begin
      unique case (psu_reg_type'(csr_paddr[4:2]))
         REG_DIMS:          csr_prdata = 32'(dims_ff);
         REG_INERTIA_START: csr_prdata = 32'(inertia_start_ff);
         REG_INERTIA_FLOOR: csr_prdata = 32'(inertia_floor_ff);
         REG_INERTIA_STEP:  csr_prdata = 32'(inertia_step_ff);
         REG_PERSONAL_W:    csr_prdata = 32'(personal_w_ff);
         REG_GLOBAL_W:      csr_prdata = 32'(global_w_ff);
         default:           csr_prdata = '0;
      endcase
   end
   assign csr_pready = 1'b1;

   // best tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         pcv_ff <= '0;
         gcost_ff <= ALL_ONES;
         gidx_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            gb_ff[i] <= '0;
         end
      end else begin
         if (pc_we) begin
            pcv_ff[state_ff == ST_IDLE ? p_req : p_cur] <= 1'b1;
         end
         if (state_ff == ST_RP_CMP && gimp_c) begin
            gcost_ff <= newpc;
            gidx_ff <= part_ff;
         end
         if (state_ff == ST_RP_CWR && gimp_ff) begin
            gb_ff[d_ff] <= pimp_ff ? pos_rd : pb_rd;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff <= '0;
      end else if (state_ff == ST_IDLE) begin
         d_ff <= '0;
      end else if ((state_ff == ST_MV_OUT && slot_free) || state_ff == ST_RP_CWR) begin
         d_ff <= d_ff + DW'(1);
      end
      if (req_fire) begin
         part_ff <= req_ch.particle;
         cost_ff <= req_ch.cost;
         cp_ff <= cp_prod[31:14];
         cg_ff <= cg_prod[31:14];
         kind_ff <= (cmd_c == CMD_ITER) ? KIND_ITER : KIND_REPORT;
         if (cmd_c == CMD_LOAD_BOUND && d_ok) begin
            lo_ff[d_req] <= req_ch.value_a;
            hi_ff[d_req] <= req_ch.value_b;
         end
      end
      if (state_ff == ST_RP_CMP) begin
         pimp_ff <= pimp_c;
         gimp_ff <= gimp_c;
      end
      if (state_ff == ST_MV_MUL) begin
         pos_ff <= pos_rd;
         t0_ff <= prod0_c <<< 2;
         t1_ff <= prod1_c;
         t2_ff <= prod2_c;
      end
      if (state_ff == ST_MV_SUM) begin
         nv_ff <= nv_c;
      end
   end

   assign rsp_ch.valid = rsp_vld_ff;
   assign rsp_ch.kind = rsp_ff.kind;
   assign rsp_ch.out_particle = rsp_ff.out_particle;
   assign rsp_ch.out_dim = rsp_ff.out_dim;
   assign rsp_ch.new_position = rsp_ff.new_position;
   assign rsp_ch.new_velocity = rsp_ff.new_velocity;
   assign rsp_ch.personal_improved = rsp_ff.personal_improved;
   assign rsp_ch.global_improved = rsp_ff.global_improved;
   assign rsp_ch.best_cost = rsp_ff.best_cost;
   assign rsp_ch.best_particle = rsp_ff.best_particle;
   assign rsp_ch.inertia_now = rsp_ff.inertia_now;
   assign rsp_ch.last = rsp_ff.last;

`ifndef NO_ASSERTIONS
   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_vld_ff || rsp_ch.ready))
      else $error("response loaded over a pending transfer");
   a_gcost_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> gcost_ff <= $past(gcost_ff))
      else $error("global best cost rose");
   a_iter_floor: assert property (@(posedge clock) disable iff (reset)
      (req_fire && cmd_c == CMD_ITER && !cfg_wr) |=> inertia_ff >= inertia_floor_ff)
      else $error("inertia below floor after iteration");
   a_move_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && state_ff == ST_MV_OUT && last_dim) |-> d_ff == dims_last)
      else $error("move ended off the last dimension");
`endif

endmodule
